>>> src/plst_pkg.sv
package plst_pkg;

    localparam int KEY_W    = 32;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 5;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int FLAG_W   = 2;

    localparam int DEF_SLOTS = 16;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef logic [FLAG_W-1:0]   flag_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam flag_t ENTRY_EMPTY    = 2'h0;
    localparam flag_t ENTRY_UNPINNED = 2'h1;
    localparam flag_t ENTRY_PINNED   = 2'h2;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam status_t STS_HIT        = 3'd0;
    localparam status_t STS_FILLED     = 3'd1;
    localparam status_t STS_LOAD_FAIL  = 3'd2;
    localparam status_t STS_NO_SLOT    = 3'd3;
    localparam status_t STS_RELEASED   = 3'd4;
    localparam status_t STS_REL_NFOUND = 3'd5;

    // search packet walking along the row of cells
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic              load_ok;
        logic              found;
        logic              have_free;
        logic              have_victim;
        logic [TIME_W-1:0] oldest;
        logic [KEY_W-1:0]  victim_key;
    } pkt_t;

    // write-back command broadcast to the cells
    typedef struct packed {
        logic              valid;
        flag_t             flag;
        logic              wr_key;
        logic              wr_time;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } wb_t;

endpackage

>>> src/plst_ifs.sv
interface plst_req_if import plst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              load_ok;

    modport source (output valid, output op, output key, output now, output load_ok,
                    input ready);
    modport sink (input valid, input op, input key, input now, input load_ok,
                  output ready);
endinterface

interface plst_rsp_if import plst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;

    modport source (output valid, output status, output slot, output evicted,
                    output evicted_key, input ready);
    modport sink (input valid, input status, input slot, input evicted,
                  input evicted_key, output ready);
endinterface

interface plst_cfg_if import plst_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] slots_in_use;

    modport source (output valid, output slots_in_use, input ready);
    modport sink (input valid, input slots_in_use, output ready);
endinterface

>>> src/plst_cell.sv
module plst_cell import plst_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS,
    parameter int IDX   = 0
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [CFG_W-1:0]         slots_in_use,
    input  pkt_t                     pkt_i,
    input  logic [$clog2(SLOTS)-1:0] found_idx_i,
    input  logic [$clog2(SLOTS)-1:0] free_idx_i,
    input  logic [$clog2(SLOTS)-1:0] victim_idx_i,
    output pkt_t                     pkt_o,
    output logic [$clog2(SLOTS)-1:0] found_idx_o,
    output logic [$clog2(SLOTS)-1:0] free_idx_o,
    output logic [$clog2(SLOTS)-1:0] victim_idx_o,
    input  wb_t                      wb_i,
    input  logic [$clog2(SLOTS)-1:0] wb_idx_i
);

    localparam int IW   = $clog2(SLOTS);
    localparam int CMPW = ((IW > CFG_W) ? IW : CFG_W) + 1;
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    flag_t             flag_reg, flag_next;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] time_reg;
    pkt_t              pkt_reg, pkt_next;
    logic [IW-1:0]     found_idx_reg, found_idx_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [IW-1:0]     victim_idx_reg, victim_idx_next;
    logic              live;
    logic              match;
    logic              wb_hit;

    assign live   = CMPW'(IDX) < CMPW'(slots_in_use);
    assign match  = (flag_reg != ENTRY_EMPTY) && (key_reg == pkt_i.key);
    assign wb_hit = wb_i.valid && (wb_idx_i == MY_IDX);

    always_comb
    begin
        pkt_next        = pkt_i;
        found_idx_next  = found_idx_i;
        free_idx_next   = free_idx_i;
        victim_idx_next = victim_idx_i;
        if (pkt_i.valid && live)
        begin
            if (!pkt_i.found && match)
            begin
                pkt_next.found = 1'b1;
                found_idx_next = MY_IDX;
            end
            if (!pkt_i.have_free)
            begin
                if (flag_reg == ENTRY_EMPTY)
                begin
                    pkt_next.have_free = 1'b1;
                    free_idx_next      = MY_IDX;
                end
                else if (flag_reg == ENTRY_UNPINNED && time_reg < pkt_i.oldest)
                begin
                    pkt_next.have_victim = 1'b1;
                    pkt_next.oldest      = time_reg;
                    pkt_next.victim_key  = key_reg;
                    victim_idx_next      = MY_IDX;
                end
            end
        end
    end

    assign flag_next = wb_hit ? wb_i.flag : flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= ENTRY_EMPTY;
            pkt_reg  <= '0;
        end
        else
        begin
            flag_reg <= flag_next;
            pkt_reg  <= pkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg  <= found_idx_next;
        free_idx_reg   <= free_idx_next;
        victim_idx_reg <= victim_idx_next;
        if (wb_hit && wb_i.wr_key)
        begin
            key_reg <= wb_i.key;
        end
        if (wb_hit && wb_i.wr_time)
        begin
            time_reg <= wb_i.now;
        end
    end

    assign pkt_o        = pkt_reg;
    assign found_idx_o  = found_idx_reg;
    assign free_idx_o   = free_idx_reg;
    assign victim_idx_o = victim_idx_reg;

endmodule

>>> src/pinned_lru_slot_table_core.sv
// the request is registered into launch_reg, passes through each cell's packet register, then into hold_reg
// the search packet visits one cell a cycle; no new request is taken until the write-back is done
// the row of cells carries the packet, then the write-back state updates the table once rsp can take the result
// reset (rst_n low, asynchronous): all slots free, slots_in_use back to 16
// no clearing pass after reset; keys and timestamps are not reset
module pinned_lru_slot_table_core import plst_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic       clk,
    input  logic       rst_n,
    plst_req_if.sink   req,
    plst_rsp_if.source rsp,
    plst_cfg_if.sink   cfg
);

    localparam int IW = $clog2(SLOTS);
    localparam int SW = (IW > SLOT_W) ? IW : SLOT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] cnt_reg;
    pkt_t             launch_reg, launch_next;
    pkt_t             hold_reg;
    logic [IW-1:0]    hold_found_reg, hold_free_reg, hold_victim_reg;

    logic             rsp_valid_reg, rsp_valid_next;
    status_t          rsp_status_reg;
    logic [SLOT_W-1:0] rsp_slot_reg;
    logic             rsp_evicted_reg;
    logic [KEY_W-1:0] rsp_ekey_reg;

    pkt_t             chain_pkt    [SLOTS+1];
    logic [IW-1:0]    chain_found  [SLOTS+1];
    logic [IW-1:0]    chain_free   [SLOTS+1];
    logic [IW-1:0]    chain_victim [SLOTS+1];

    logic             accept;
    logic             wb_fire;
    status_t          status_c;
    logic [IW-1:0]    slot_idx_c;
    logic [SW-1:0]    slot_ext;
    logic             evicted_c;
    logic [KEY_W-1:0] ekey_c;
    logic             wb_req_c;
    flag_t            wb_flag_c;
    logic             wb_wr_c;
    wb_t              wb;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign wb_fire   = (state_reg == S_WB) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        launch_next             = '0;
        launch_next.valid       = accept;
        launch_next.op          = req.op;
        launch_next.key         = req.key;
        launch_next.now         = req.now;
        launch_next.load_ok     = req.load_ok;
        launch_next.oldest      = req.now;
    end

    assign chain_pkt[0]    = launch_reg;
    assign chain_found[0]  = '0;
    assign chain_free[0]   = '0;
    assign chain_victim[0] = '0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        plst_cell #(
            .SLOTS (SLOTS),
            .IDX   (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .slots_in_use (cnt_reg),
            .pkt_i        (chain_pkt[g]),
            .found_idx_i  (chain_found[g]),
            .free_idx_i   (chain_free[g]),
            .victim_idx_i (chain_victim[g]),
            .pkt_o        (chain_pkt[g+1]),
            .found_idx_o  (chain_found[g+1]),
            .free_idx_o   (chain_free[g+1]),
            .victim_idx_o (chain_victim[g+1]),
            .wb_i         (wb),
            .wb_idx_i     (slot_idx_c)
        );
    end

    // outcome of the finished search
    always_comb
    begin
        status_c   = STS_NO_SLOT;
        slot_idx_c = '0;
        evicted_c  = 1'b0;
        ekey_c     = '0;
        wb_req_c   = 1'b0;
        wb_flag_c  = ENTRY_EMPTY;
        wb_wr_c    = 1'b0;
        if (hold_reg.op == OP_RELEASE)
        begin
            if (hold_reg.found)
            begin
                status_c   = STS_RELEASED;
                slot_idx_c = hold_found_reg;
                wb_req_c   = 1'b1;
                wb_flag_c  = ENTRY_UNPINNED;
            end
            else
            begin
                status_c = STS_REL_NFOUND;
            end
        end
        else if (hold_reg.found)
        begin
            status_c   = STS_HIT;
            slot_idx_c = hold_found_reg;
            wb_req_c   = 1'b1;
            wb_flag_c  = ENTRY_PINNED;
        end
        else if (hold_reg.have_free || hold_reg.have_victim)
        begin
            if (hold_reg.have_free)
            begin
                slot_idx_c = hold_free_reg;
            end
            else
            begin
                slot_idx_c = hold_victim_reg;
                evicted_c  = 1'b1;
                ekey_c     = hold_reg.victim_key;
            end
            wb_req_c = 1'b1;
            if (hold_reg.load_ok)
            begin
                status_c  = STS_FILLED;
                wb_flag_c = ENTRY_PINNED;
                wb_wr_c   = 1'b1;
            end
            else
            begin
                status_c  = STS_LOAD_FAIL;
                wb_flag_c = ENTRY_EMPTY;
            end
        end
    end

    always_comb
    begin
        wb.valid   = wb_fire && wb_req_c;
        wb.flag    = wb_flag_c;
        wb.wr_key  = wb_wr_c;
        wb.wr_time = wb_wr_c || (hold_reg.op == OP_ACQUIRE && hold_reg.found);
        wb.key     = hold_reg.key;
        wb.now     = hold_reg.now;
    end

    assign slot_ext = SW'(slot_idx_c);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chain_pkt[SLOTS].valid)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (wb_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (wb_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= CFG_RESET;
            launch_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                cnt_reg <= cfg.slots_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && chain_pkt[SLOTS].valid)
        begin
            hold_reg        <= chain_pkt[SLOTS];
            hold_found_reg  <= chain_found[SLOTS];
            hold_free_reg   <= chain_free[SLOTS];
            hold_victim_reg <= chain_victim[SLOTS];
        end
        if (wb_fire)
        begin
            rsp_status_reg  <= status_c;
            rsp_slot_reg    <= slot_ext[SLOT_W-1:0];
            rsp_evicted_reg <= evicted_c;
            rsp_ekey_reg    <= ekey_c;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.slot        = rsp_slot_reg;
    assign rsp.evicted     = rsp_evicted_reg;
    assign rsp.evicted_key = rsp_ekey_reg;

    a_tail_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
        chain_pkt[SLOTS].valid |-> state_reg == S_SCAN)
        else $error("search packet left the row outside a scan");

    a_launch_after_transfer : assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg.valid |-> $past(req.valid && req.ready))
        else $error("packet launched without an input transfer");

    a_evict_on_miss : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.evicted |-> (rsp.status == STS_FILLED || rsp.status == STS_LOAD_FAIL))
        else $error("eviction reported outside a miss");

    a_wb_then_idle : assert property (@(posedge clk) disable iff (!rst_n)
        wb_fire |=> req.ready && rsp.valid)
        else $error("write-back not followed by result and idle");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

import plst_pkg::*;

typedef struct {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              load_ok;
} slot_request_t;

typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
} slot_outcome_t;

class slot_table_scoreboard;
    flag_t             flag_of  [DEF_SLOTS];
    logic [KEY_W-1:0]  key_of   [DEF_SLOTS];
    logic [TIME_W-1:0] stamp_of [DEF_SLOTS];
    logic [CFG_W-1:0]  slots_in_use;
    slot_outcome_t     awaited_outcomes[$];
    int unsigned       error_count;

    function new();
        slots_in_use = CFG_RESET;
        error_count = 0;
        foreach (flag_of[i])
        begin
            flag_of[i] = ENTRY_EMPTY;
            key_of[i] = '0;
            stamp_of[i] = '0;
        end
    endfunction

    function void set_slots_in_use(input logic [CFG_W-1:0] value);
        slots_in_use = value;
    endfunction

    function slot_outcome_t resolve_request(input slot_request_t r);
        slot_outcome_t     res;
        int                live;
        int                match_at;
        int                free_at;
        int                victim_at;
        logic [TIME_W-1:0] oldest;

        res.status = STS_HIT;
        res.slot = '0;
        res.evicted = 1'b0;
        res.evicted_key = '0;
        live = (slots_in_use > DEF_SLOTS) ? DEF_SLOTS : int'(slots_in_use);
        match_at = -1;
        for (int i = 0; i < live; i++)
        begin
            if (flag_of[i] != ENTRY_EMPTY && key_of[i] == r.key)
            begin
                match_at = i;
                break;
            end
        end

        if (r.op == OP_RELEASE)
        begin
            if (match_at >= 0)
            begin
                flag_of[match_at] = ENTRY_UNPINNED;
                res.status = STS_RELEASED;
                res.slot = SLOT_W'(match_at);
            end
            else
            begin
                res.status = STS_REL_NFOUND;
            end
            return res;
        end

        if (match_at >= 0)
        begin
            flag_of[match_at] = ENTRY_PINNED;
            stamp_of[match_at] = r.now;
            res.status = STS_HIT;
            res.slot = SLOT_W'(match_at);
            return res;
        end

        free_at = -1;
        victim_at = -1;
        oldest = r.now;
        for (int i = 0; i < live; i++)
        begin
            if (flag_of[i] == ENTRY_EMPTY)
            begin
                free_at = i;
                break;
            end
            if (flag_of[i] == ENTRY_UNPINNED && stamp_of[i] < oldest)
            begin
                oldest = stamp_of[i];
                victim_at = i;
            end
        end

        if (free_at < 0 && victim_at >= 0)
        begin
            res.evicted = 1'b1;
            res.evicted_key = key_of[victim_at];
            flag_of[victim_at] = ENTRY_EMPTY;
            free_at = victim_at;
        end

        if (free_at >= 0)
        begin
            res.slot = SLOT_W'(free_at);
            if (r.load_ok)
            begin
                flag_of[free_at] = ENTRY_PINNED;
                key_of[free_at] = r.key;
                stamp_of[free_at] = r.now;
                res.status = STS_FILLED;
            end
            else
            begin
                res.status = STS_LOAD_FAIL;
            end
        end
        else
        begin
            res.status = STS_NO_SLOT;
            res.slot = '0;
        end
        return res;
    endfunction

    function void note_request(input slot_request_t r);
        awaited_outcomes.push_back(resolve_request(r));
    endfunction

    function void check_outcome(input slot_outcome_t got);
        slot_outcome_t want;

        if (awaited_outcomes.size() == 0)
        begin
            $error("unexpected result transfer: status %0d slot %0d", got.status, got.slot);
            error_count++;
            return;
        end
        want = awaited_outcomes.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
        end
        if (got.slot !== want.slot)
        begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            error_count++;
        end
        if (got.evicted !== want.evicted)
        begin
            $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
            error_count++;
        end
        if (got.evicted_key !== want.evicted_key)
        begin
            $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
            error_count++;
        end
    endfunction
endclass

module testbench;
    localparam int SETTLE = DEF_SLOTS + 3;
    localparam int LIMIT  = 400000;
    localparam int PHASES = 11;

    logic clk;
    logic rst_n;
    logic quiet;
    int unsigned cycle_count = 0;
    logic [TIME_W-1:0] clock_now;
    logic [KEY_W-1:0] key_pool[$];
    slot_table_scoreboard board;

    plst_req_if req_bus ();
    plst_rsp_if rsp_bus ();
    plst_cfg_if cfg_bus ();

    pinned_lru_slot_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("** pinned_lru_slot_table_core: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        slot_request_t taken;
        slot_outcome_t seen;

        if (rst_n === 1'b1)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                seen.status = rsp_bus.status;
                seen.slot = rsp_bus.slot;
                seen.evicted = rsp_bus.evicted;
                seen.evicted_key = rsp_bus.evicted_key;
                board.check_outcome(seen);
            end
            if (req_bus.valid && req_bus.ready)
            begin
                taken.op = req_bus.op;
                taken.key = req_bus.key;
                taken.now = req_bus.now;
                taken.load_ok = req_bus.load_ok;
                board.note_request(taken);
            end
            if (cfg_bus.valid && cfg_bus.ready)
                board.set_slots_in_use(cfg_bus.slots_in_use);
        end
    end

    task automatic run_receiver();
        int unsigned stall;

        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_bus.valid) @(posedge clk);
        end
    endtask

    task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [TIME_W-1:0] now, input logic load_ok);
        int unsigned gap;

        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.op <= op;
        req_bus.key <= key;
        req_bus.now <= now;
        req_bus.load_ok <= load_ok;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
    endtask

    task automatic drain_results(input int unsigned settle);
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.awaited_outcomes.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_slots_in_use(input logic [CFG_W-1:0] value);
        drain_results(SETTLE);
        cfg_bus.valid <= 1'b1;
        cfg_bus.slots_in_use <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_random_request();
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic              load_ok;
        int unsigned       roll;

        roll = $urandom_range(0, 99);
        key = (roll < 85) ? key_pool[$urandom_range(0, key_pool.size() - 1)] : $urandom;
        op = ($urandom_range(0, 99) < 35) ? OP_RELEASE : OP_ACQUIRE;
        load_ok = ($urandom_range(0, 99) < 85);
        roll = $urandom_range(0, 99);
        if (roll < 4)
            now = $urandom;
        else if (roll < 5)
            now = '0;
        else if (roll < 6)
            now = '1;
        else
        begin
            clock_now = clock_now + $urandom_range(0, 3);
            now = clock_now;
        end
        if ($urandom_range(0, 99) < 3)
            quiet = ~quiet;
        send_request(op, key, now, load_ok);
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_setting [PHASES];
        int unsigned      live;
        int unsigned      pool_size;
        int unsigned      item_total;
        int unsigned      pause_at;

        board = new();
        quiet = 1'b0;
        clock_now = 32'd1000;
        phase_setting = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd2, 5'd0, 5'd8, 5'd17, 5'd3,
                          5'd16, 5'd0};
        phase_setting[PHASES-1] = CFG_W'($urandom_range(0, 31));

        rst_n <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.op <= OP_ACQUIRE;
        req_bus.key <= '0;
        req_bus.now <= '0;
        req_bus.load_ok <= 1'b0;
        rsp_bus.ready <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.slots_in_use <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        fork
            run_receiver();
        join_none
        @(posedge clk);

        // empty table, load failure, fill, hit, release twice
        send_request(OP_RELEASE, 32'h5, 32'd1, 1'b1);
        send_request(OP_ACQUIRE, 32'h0, 32'd10, 1'b0);
        send_request(OP_ACQUIRE, 32'h0, 32'd10, 1'b1);
        send_request(OP_ACQUIRE, 32'h0, 32'd11, 1'b1);
        send_request(OP_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_RELEASE, 32'h0, 32'd12, 1'b0);
        send_request(OP_RELEASE, 32'h0, 32'd12, 1'b1);

        // two slots: blocked eviction, eviction with failed load, refill
        write_slots_in_use(5'd2);
        send_request(OP_ACQUIRE, 32'h7, 32'd5, 1'b1);
        send_request(OP_ACQUIRE, 32'h7, 32'd20, 1'b0);
        send_request(OP_ACQUIRE, 32'h7, 32'd21, 1'b1);
        send_request(OP_RELEASE, 32'hFFFF_FFFF, 32'd21, 1'b0);
        send_request(OP_ACQUIRE, 32'h9, 32'd0, 1'b1);
        send_request(OP_RELEASE, 32'h7, 32'd22, 1'b1);
        send_request(OP_ACQUIRE, 32'h9, 32'd30, 1'b1);

        // no slot in use, then out of range counts
        write_slots_in_use(5'd0);
        send_request(OP_ACQUIRE, 32'h9, 32'd31, 1'b1);
        send_request(OP_RELEASE, 32'h9, 32'd31, 1'b1);
        write_slots_in_use(5'd31);
        send_request(OP_ACQUIRE, 32'h9, 32'd32, 1'b1);
        send_request(OP_ACQUIRE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        send_request(OP_RELEASE, 32'h5555_5555, 32'd33, 1'b0);
        write_slots_in_use(5'd17);
        send_request(OP_RELEASE, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b1);
        write_slots_in_use(5'd1);
        send_request(OP_ACQUIRE, 32'h1, 32'd40, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            write_slots_in_use(phase_setting[p]);
            live = (phase_setting[p] > DEF_SLOTS) ? DEF_SLOTS : phase_setting[p];
            pool_size = $urandom_range(2, 2 * live + 4);
            key_pool.delete();
            for (int k = 0; k < pool_size; k++)
                key_pool.push_back($urandom);
            if ($urandom_range(0, 1) == 1)
                key_pool.push_back('0);
            if ($urandom_range(0, 1) == 1)
                key_pool.push_back('1);
            quiet = ($urandom_range(0, 3) == 0);
            item_total = (phase_setting[p] == 0) ? 20 : 105;
            pause_at = $urandom_range(5, item_total - 5);
            for (int n = 0; n < item_total; n++)
            begin
                if (n == pause_at)
                    drain_results(0);
                send_random_request();
            end
        end

        drain_results(SETTLE);
        if (board.error_count == 0)
            $display("** pinned_lru_slot_table_core: PASSED **");
        else
            $display("** pinned_lru_slot_table_core: FAILED **");
        $finish;
    end
endmodule
